>>> hdl/drs_pkg.sv
// ---------------------------------------------------------------------------
// drs_pkg: shared types and constants of the disk request scheduler.
// Holds the queue geometry, the policy and status codes and the sequencer
// states that the scheduler modules have in common.
// ---------------------------------------------------------------------------
package drs_pkg;

  localparam int QueueDepth = 64;
  localparam int TrackBits  = 16;
  localparam int TagBits    = 16;
  localparam int IdxBits    = $clog2(QueueDepth);
  localparam int CntBits    = $clog2(QueueDepth + 1);

  localparam logic [2:0] ModeFifo  = 3'd0;
  localparam logic [2:0] ModeSstf  = 3'd1;
  localparam logic [2:0] ModeLook  = 3'd2;
  localparam logic [2:0] ModeClook = 3'd3;
  localparam logic [2:0] ModeFlook = 3'd4;

  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusEmpty = 2'd1;
  localparam logic [1:0] StatusFull  = 2'd2;

  localparam logic OpAdd  = 1'b0;
  localparam logic OpPick = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StCopy,
    StScan,
    StShift,
    StDone
  } state_e;

endpackage

>>> hdl/drs_best_unit.sv
// ---------------------------------------------------------------------------
// drs_best_unit: shared compare unit of the scheduler.
// Takes one queued track a cycle while step_i is high and keeps the running
// best candidates for SSTF, LOOK, F-LOOK and C-LOOK, so that a pick needs a single pass over the queue.
// ---------------------------------------------------------------------------
module drs_best_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           clear_i,
  input  logic                           step_i,
  input  logic [drs_pkg::IdxBits-1:0]    idx_i,
  input  logic [drs_pkg::TrackBits-1:0]  track_i,
  input  logic signed [drs_pkg::TrackBits:0] head_i,
  input  logic                           sweep_up_i,
  input  logic [2:0]                     mode_i,
  output logic [drs_pkg::IdxBits-1:0]    pick_idx_o,
  output logic                           flip_o
);

  localparam int DW = drs_pkg::TrackBits + 2;

  logic signed [DW-1:0] t_s, h_s, diff;
  logic [DW-1:0] abs_diff;
  logic has_up_q, has_dn_q, has_a_q, has_w_q, has_s_q;
  logic has_up_d, has_dn_d, has_a_d, has_w_d, has_s_d;
  logic [drs_pkg::TrackBits-1:0] up_t_q, dn_t_q, a_t_q, w_t_q;
  logic [drs_pkg::TrackBits-1:0] up_t_d, dn_t_d, a_t_d, w_t_d;
  logic [DW-1:0] s_d_q, s_d_d;
  logic [drs_pkg::IdxBits-1:0] up_i_q, dn_i_q, a_i_q, w_i_q, s_i_q;
  logic [drs_pkg::IdxBits-1:0] up_i_d, dn_i_d, a_i_d, w_i_d, s_i_d;
  logic gt, lt;

  // Signed distance between the entry and the head.
  always_comb begin
    t_s      = $signed({2'b00, track_i});
    h_s      = DW'(head_i);
    diff     = t_s - h_s;
    abs_diff = diff[DW-1] ? DW'(-diff) : DW'(diff);
    gt       = t_s > h_s;
    lt       = t_s < h_s;
  end

  // Candidate update for one entry.
  always_comb begin
    has_up_d = has_up_q; up_t_d = up_t_q; up_i_d = up_i_q;
    has_dn_d = has_dn_q; dn_t_d = dn_t_q; dn_i_d = dn_i_q;
    has_a_d  = has_a_q;  a_t_d  = a_t_q;  a_i_d  = a_i_q;
    has_w_d  = has_w_q;  w_t_d  = w_t_q;  w_i_d  = w_i_q;
    has_s_d  = has_s_q;  s_d_d  = s_d_q;  s_i_d  = s_i_q;
    if (step_i) begin
      if (!has_s_q || abs_diff < s_d_q) begin
        has_s_d = 1'b1; s_d_d = abs_diff; s_i_d = idx_i;
      end
      if (gt) begin
        if (!has_up_q || track_i < up_t_q) begin
          has_up_d = 1'b1; up_t_d = track_i; up_i_d = idx_i;
        end
      end else if (lt) begin
        if (!has_dn_q || track_i > dn_t_q) begin
          has_dn_d = 1'b1; dn_t_d = track_i; dn_i_d = idx_i;
        end
      end else if (sweep_up_i) begin
        has_up_d = 1'b1; up_t_d = track_i; up_i_d = idx_i;
      end else begin
        has_dn_d = 1'b1; dn_t_d = track_i; dn_i_d = idx_i;
      end
      if (!lt) begin
        if (!has_a_q || track_i < a_t_q) begin
          has_a_d = 1'b1; a_t_d = track_i; a_i_d = idx_i;
        end
      end else begin
        if (!has_w_q || track_i < w_t_q) begin
          has_w_d = 1'b1; w_t_d = track_i; w_i_d = idx_i;
        end
      end
    end
  end

  // Candidate registers; valid flags cleared at the start of each pick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_up_q <= 1'b0; has_dn_q <= 1'b0; has_a_q <= 1'b0;
      has_w_q  <= 1'b0; has_s_q  <= 1'b0;
    end else if (clear_i) begin
      has_up_q <= 1'b0; has_dn_q <= 1'b0; has_a_q <= 1'b0;
      has_w_q  <= 1'b0; has_s_q  <= 1'b0;
    end else begin
      has_up_q <= has_up_d; has_dn_q <= has_dn_d; has_a_q <= has_a_d;
      has_w_q  <= has_w_d;  has_s_q  <= has_s_d;
    end
  end

  always_ff @(posedge clk_i) begin
    up_t_q <= up_t_d; up_i_q <= up_i_d;
    dn_t_q <= dn_t_d; dn_i_q <= dn_i_d;
    a_t_q  <= a_t_d;  a_i_q  <= a_i_d;
    w_t_q  <= w_t_d;  w_i_q  <= w_i_d;
    s_d_q  <= s_d_d;  s_i_q  <= s_i_d;
  end

  // Final choice per policy; missing candidates fall back to entry zero.
  always_comb begin
    flip_o     = 1'b0;
    pick_idx_o = '0;
    unique case (mode_i)
      drs_pkg::ModeSstf:  pick_idx_o = s_i_q;
      drs_pkg::ModeLook, drs_pkg::ModeFlook: begin
        if (sweep_up_i) begin
          if (has_up_q) pick_idx_o = up_i_q;
          else begin
            flip_o = 1'b1;
            pick_idx_o = has_dn_q ? dn_i_q : '0;
          end
        end else begin
          if (has_dn_q) pick_idx_o = dn_i_q;
          else begin
            flip_o = 1'b1;
            pick_idx_o = has_up_q ? up_i_q : '0;
          end
        end
      end
      drs_pkg::ModeClook: pick_idx_o = has_a_q ? a_i_q : (has_w_q ? w_i_q : '0);
      default:            pick_idx_o = '0;
    endcase
  end

endmodule

>>> hdl/disk_request_scheduler_core.sv
// Timing: an add or an empty pick presents its result in the cycle after it is
// accepted; a pick scans every queued entry, then moves each entry after the
// chosen one one place down, then presents the result; when an F-LOOK batch
// is frozen, the waiting entries are first copied into the active queue.
// One transaction at a time: the input stalls until the result is taken.
// Reset: counts clear, sweep direction is upward, mode is FIFO.
// ---------------------------------------------------------------------------
// disk_request_scheduler_core: top level of the disk request scheduler.
// Keeps active and waiting request queues in memories and picks the next
// request under a small sequencer driving the shared compare unit.
// ---------------------------------------------------------------------------
module disk_request_scheduler_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          op_i,
  input  logic [drs_pkg::TagBits-1:0]   req_tag_i,
  input  logic [drs_pkg::TrackBits-1:0] track_i,
  input  logic signed [drs_pkg::TrackBits:0] head_pos_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    status_o,
  output logic [drs_pkg::TagBits-1:0]   chosen_tag_o,
  output logic [drs_pkg::TrackBits-1:0] chosen_track_o
);

  localparam int IW = drs_pkg::IdxBits;
  localparam int CW = drs_pkg::CntBits;
  localparam int EW = drs_pkg::TagBits + drs_pkg::TrackBits;

  drs_pkg::state_e state_q, state_d;
  logic [2:0]  mode_q;
  logic [CW-1:0] act_cnt_q, act_cnt_d, wait_cnt_q, wait_cnt_d;
  logic        sweep_q, sweep_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic [IW-1:0] sel_q, sel_d;
  logic signed [drs_pkg::TrackBits:0] head_q;
  logic        out_valid_q, out_valid_d;
  logic [1:0]  status_q, status_d;
  logic [drs_pkg::TagBits-1:0]   otag_q, otag_d;
  logic [drs_pkg::TrackBits-1:0] otrk_q, otrk_d;

  logic [EW-1:0] act_mem [drs_pkg::QueueDepth];
  logic [EW-1:0] wait_mem [drs_pkg::QueueDepth];
  logic [EW-1:0] act_rd_q, wait_rd_q;
  logic          act_we, wait_we;
  logic [IW-1:0] act_wa, act_ra, wait_ra;
  logic [EW-1:0] act_wd;
  logic          rd_vld_q, rd_vld_d;
  logic [IW-1:0] rd_idx_q;

  logic          accept, bu_clear, bu_step, bu_flip;
  logic [IW-1:0] bu_idx;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != drs_pkg::StIdle) || out_valid_q;
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign chosen_tag_o   = otag_q;
  assign chosen_track_o = otrk_q;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mode_q <= drs_pkg::ModeFifo;
    else if (cfg_we_i) mode_q <= cfg_wdata_i;
  end

  // Queue memories: one write and one registered read each.
  always_ff @(posedge clk_i) begin
    if (act_we) act_mem[act_wa] <= act_wd;
    act_rd_q <= act_mem[act_ra];
    if (wait_we) wait_mem[IW'(wait_cnt_q)] <= {req_tag_i, track_i};
    wait_rd_q <= wait_mem[wait_ra];
  end

  drs_best_unit u_best (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (bu_clear),
    .step_i     (bu_step),
    .idx_i      (rd_idx_q),
    .track_i    (act_rd_q[drs_pkg::TrackBits-1:0]),
    .head_i     (head_q),
    .sweep_up_i (sweep_q),
    .mode_i     (mode_q),
    .pick_idx_o (bu_idx),
    .flip_o     (bu_flip)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      drs_pkg::StIdle: begin
        if (accept && op_i == drs_pkg::OpPick) begin
          if (mode_q == drs_pkg::ModeFlook && act_cnt_q == '0 && wait_cnt_q != '0)
            state_d = drs_pkg::StCopy;
          else if (act_cnt_q == '0) state_d = drs_pkg::StIdle;
          else state_d = drs_pkg::StScan;
        end
      end
      drs_pkg::StCopy: if (ptr_q == wait_cnt_q) state_d = drs_pkg::StScan;
      drs_pkg::StScan: if (ptr_q == act_cnt_q && !rd_vld_q) state_d = drs_pkg::StShift;
      drs_pkg::StShift: if (rd_vld_q && ptr_q >= act_cnt_q) state_d = drs_pkg::StDone;
      drs_pkg::StDone: state_d = drs_pkg::StIdle;
      default: state_d = drs_pkg::StIdle;
    endcase
  end

  // Datapath and output control of the sequencer.
  always_comb begin
    act_cnt_d = act_cnt_q; wait_cnt_d = wait_cnt_q; sweep_d = sweep_q;
    ptr_d = ptr_q; sel_d = sel_q; rd_vld_d = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    status_d = status_q; otag_d = otag_q; otrk_d = otrk_q;
    act_we = 1'b0; act_wa = '0; act_wd = '0; act_ra = '0;
    wait_we = 1'b0; wait_ra = '0;
    bu_clear = 1'b0; bu_step = 1'b0;
    unique case (state_q)
      drs_pkg::StIdle: begin
        ptr_d = '0; bu_clear = 1'b1;
        if (accept) begin
          otag_d = '0; otrk_d = '0; status_d = drs_pkg::StatusOk;
          if (op_i == drs_pkg::OpAdd) begin
            out_valid_d = 1'b1;
            if (mode_q == drs_pkg::ModeFlook) begin
              if (wait_cnt_q == CW'(drs_pkg::QueueDepth)) status_d = drs_pkg::StatusFull;
              else begin wait_we = 1'b1; wait_cnt_d = wait_cnt_q + 1'b1; end
            end else begin
              if (act_cnt_q == CW'(drs_pkg::QueueDepth)) status_d = drs_pkg::StatusFull;
              else begin
                act_we = 1'b1; act_wa = IW'(act_cnt_q);
                act_wd = {req_tag_i, track_i};
                act_cnt_d = act_cnt_q + 1'b1;
              end
            end
          end else if (!(mode_q == drs_pkg::ModeFlook && wait_cnt_q != '0)
                       && act_cnt_q == '0) begin
            out_valid_d = 1'b1; status_d = drs_pkg::StatusEmpty;
          end
        end
      end
      drs_pkg::StCopy: begin
        // Read waiting entry ptr and write it to the active queue in the next cycle.
        wait_ra = IW'(ptr_q);
        rd_vld_d = ptr_q != wait_cnt_q;
        if (ptr_q != wait_cnt_q) ptr_d = ptr_q + 1'b1;
        if (rd_vld_q) begin
          act_we = 1'b1; act_wa = IW'(ptr_q - 1'b1); act_wd = wait_rd_q;
        end
        if (ptr_q == wait_cnt_q) begin
          act_cnt_d = wait_cnt_q; wait_cnt_d = '0; ptr_d = '0;
        end
      end
      drs_pkg::StScan: begin
        act_ra = IW'(ptr_q);
        bu_step = rd_vld_q;
        if (ptr_q != act_cnt_q) begin
          rd_vld_d = 1'b1; ptr_d = ptr_q + 1'b1;
        end
        if (ptr_q == act_cnt_q && !rd_vld_q) begin
          sel_d = bu_idx;
          if (bu_flip) sweep_d = !sweep_q;
          ptr_d = CW'(bu_idx);
        end
      end
      drs_pkg::StShift: begin
        // Read entry ptr; the entry read last cycle goes one place down,
        // except the chosen one, which is captured for the result.
        act_ra = IW'(ptr_q);
        if (ptr_q < act_cnt_q) begin rd_vld_d = 1'b1; ptr_d = ptr_q + 1'b1; end
        if (rd_vld_q) begin
          if (rd_idx_q == sel_q) begin
            otag_d = act_rd_q[EW-1 -: drs_pkg::TagBits];
            otrk_d = act_rd_q[drs_pkg::TrackBits-1:0];
          end else begin
            act_we = 1'b1; act_wa = rd_idx_q - 1'b1; act_wd = act_rd_q;
          end
        end
        if (rd_vld_q && ptr_q >= act_cnt_q) begin
          act_cnt_d = act_cnt_q - 1'b1;
        end
      end
      drs_pkg::StDone: begin
        out_valid_d = 1'b1; status_d = drs_pkg::StatusOk;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= drs_pkg::StIdle; act_cnt_q <= '0; wait_cnt_q <= '0;
      sweep_q <= 1'b1; ptr_q <= '0; rd_vld_q <= 1'b0; out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d; act_cnt_q <= act_cnt_d; wait_cnt_q <= wait_cnt_d;
      sweep_q <= sweep_d; ptr_q <= ptr_d; rd_vld_q <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) head_q <= head_pos_i;
    sel_q <= sel_d; rd_idx_q <= IW'(ptr_q);
    status_q <= status_d; otag_q <= otag_d; otrk_q <= otrk_d;
  end

endmodule
